>>> src/cbt_pkg.sv
package cbt_pkg;

   // coordinate format, signed q16.16 at the default width
   localparam int COORD_WIDTH = 32;
   // curve parameter t, unsigned q0.16 with room for 1.0
   localparam int T_W = 17;
   localparam logic [T_W-1:0] T_ONE = 17'h10000;
   localparam logic [T_W-1:0] STEP_MIN = 17'd1040;
   localparam logic [T_W-1:0] STEP_RESET = 17'd4096;
   // weights carry WGT_FRAC fraction bits, dropped from the exact q0.48 form
   localparam int WGT_FRAC = 60 - COORD_WIDTH;
   localparam int WGT_DROP = 48 - WGT_FRAC;
   localparam int WGT_W = WGT_FRAC + 1;
   localparam int SQ_W = 2 * T_W;
   localparam int CUBE_W = 3 * T_W + 1;
   localparam int PROD_W = WGT_W + 1 + COORD_WIDTH;
   localparam int PAIR_W = PROD_W + 1;
   localparam int ACC_W = 64;
   localparam int Q_W = ACC_W + 1 - WGT_FRAC;
   localparam int SEG_POINTS = 4;
   localparam int IDX_W = 2;
   localparam int CNT_W = 3;
   localparam int AXES = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WGT1,
      ST_WGT2,
      ST_PROD,
      ST_SUM1,
      ST_SUM2,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic accept;
      logic wgt1;
      logic wgt2;
      logic prod;
      logic sum1;
      logic sum2;
      logic push;
   } cmd_type;

   typedef struct packed {
      logic seg_close;
      logic is_last;
   } status_type;

endpackage

>>> src/cbt_ctrl.sv
module cbt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  cbt_pkg::status_type status,
   output cbt_pkg::cmd_type    cmd
);
   import cbt_pkg::*;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && status.seg_close) state_in = ST_WGT1;
         end
         ST_WGT1: begin
            cmd.wgt1 = 1'b1;
            state_in = ST_WGT2;
         end
         ST_WGT2: begin
            cmd.wgt2 = 1'b1;
            state_in = ST_PROD;
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = ST_SUM1;
         end
         ST_SUM1: begin
            cmd.sum1 = 1'b1;
            state_in = ST_SUM2;
         end
         ST_SUM2: begin
            cmd.sum2 = 1'b1;
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (out_free) begin
               cmd.push = 1'b1;
               state_in = status.is_last ? ST_IDLE : ST_WGT1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (cmd.push) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   a_push_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH && !out_free) |=> (state_ff == ST_PUSH))
      else $error("sample left push state while output word was blocked");

   a_close_starts: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && status.seg_close) |=> (state_ff == ST_WGT1))
      else $error("closing point did not start sampling");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> rsp_valid_ff)
      else $error("pushed sample not presented");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && state_ff == ST_IDLE))
      else $error("control not cleared by reset");

endmodule

>>> src/cbt_datapath.sv
module cbt_datapath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  cbt_pkg::cmd_type                          cmd,
   output cbt_pkg::status_type                       status,
   input  logic                                     csr_write_enable,
   input  logic [cbt_pkg::T_W-1:0]                   csr_write_data,
   input  logic                                     req_start_curve,
   input  logic signed [cbt_pkg::COORD_WIDTH-1:0]    req_point_x,
   input  logic signed [cbt_pkg::COORD_WIDTH-1:0]    req_point_y,
   input  logic signed [cbt_pkg::COORD_WIDTH-1:0]    req_point_z,
   output logic signed [cbt_pkg::COORD_WIDTH-1:0]    rsp_curve_x,
   output logic signed [cbt_pkg::COORD_WIDTH-1:0]    rsp_curve_y,
   output logic signed [cbt_pkg::COORD_WIDTH-1:0]    rsp_curve_z,
   output logic                                     rsp_segment_last
);
   import cbt_pkg::*;

   localparam logic signed [Q_W-1:0] SAT_MAX = Q_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
   localparam logic signed [Q_W-1:0] SAT_MIN = -SAT_MAX - Q_W'(1);

   function automatic logic [WGT_W-1:0] round_wgt(input logic [CUBE_W-1:0] x);
      logic [CUBE_W-1:0] s;
      s = (x + (CUBE_W'(1) << (WGT_DROP - 1))) >> WGT_DROP;
      return s[WGT_W-1:0];
   endfunction

   logic [T_W-1:0] step_cfg_ff, step_ff, t_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic signed [COORD_WIDTH-1:0] pt_ff [AXES][SEG_POINTS];
   logic [SQ_W-1:0] uu_ff, ut_ff, tt_ff;
   logic [WGT_W-1:0] w_ff [SEG_POINTS];
   logic signed [PROD_W-1:0] prod_ff [AXES][SEG_POINTS];
   logic signed [PAIR_W-1:0] pair_ff [AXES][2];
   logic signed [ACC_W-1:0] acc_ff [AXES];
   logic signed [COORD_WIDTH-1:0] crv_ff [AXES];
   logic last_ff;

   logic signed [COORD_WIDTH-1:0] pin [AXES];
   logic [IDX_W-1:0] idx;
   logic [CNT_W-1:0] cnt_new;
   logic [T_W-1:0] u;
   logic [CUBE_W-1:0] m0, m1, m2, m3;
   logic signed [COORD_WIDTH-1:0] crv_new [AXES];
   logic signed [ACC_W:0] biased [AXES];
   logic signed [Q_W-1:0] q [AXES];

   assign pin[0] = req_point_x;
   assign pin[1] = req_point_y;
   assign pin[2] = req_point_z;

   // new curve or full set restarts at entry zero
   assign idx = (req_start_curve || cnt_ff >= CNT_W'(SEG_POINTS)) ? '0 : cnt_ff[IDX_W-1:0];
   assign cnt_new = CNT_W'(idx) + CNT_W'(1);
   assign status.seg_close = (cnt_new == CNT_W'(SEG_POINTS));
   assign status.is_last = ({1'b0, t_ff} + {1'b0, step_ff}) > {1'b0, T_ONE};

   assign u  = T_ONE - t_ff;
   assign m0 = CUBE_W'(uu_ff) * CUBE_W'(u);
   assign m1 = CUBE_W'(ut_ff) * CUBE_W'(u);
   assign m2 = CUBE_W'(ut_ff) * CUBE_W'(t_ff);
   assign m3 = CUBE_W'(tt_ff) * CUBE_W'(t_ff);

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         biased[a] = (ACC_W+1)'(acc_ff[a]) + ((ACC_W+1)'(1) <<< (WGT_FRAC - 1));
         q[a] = Q_W'(biased[a] >>> WGT_FRAC);
         if (q[a] > SAT_MAX) crv_new[a] = COORD_WIDTH'(SAT_MAX);
         else if (q[a] < SAT_MIN) crv_new[a] = COORD_WIDTH'(SAT_MIN);
         else crv_new[a] = q[a][COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_cfg_ff <= STEP_RESET;
         cnt_ff      <= '0;
      end else begin
         if (csr_write_enable) step_cfg_ff <= csr_write_data;
         if (cmd.accept) cnt_ff <= cnt_new;
         else if (cmd.push && status.is_last) cnt_ff <= CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         for (int a = 0; a < AXES; a++) pt_ff[a][idx] <= pin[a];
         t_ff    <= '0;
         step_ff <= (step_cfg_ff < STEP_MIN) ? STEP_MIN : step_cfg_ff;
      end
      if (cmd.wgt1) begin
         uu_ff <= SQ_W'(u) * SQ_W'(u);
         ut_ff <= SQ_W'(u) * SQ_W'(t_ff);
         tt_ff <= SQ_W'(t_ff) * SQ_W'(t_ff);
      end
      if (cmd.wgt2) begin
         w_ff[0] <= round_wgt(m0);
         w_ff[1] <= round_wgt(m1 + (m1 << 1));
         w_ff[2] <= round_wgt(m2 + (m2 << 1));
         w_ff[3] <= round_wgt(m3);
      end
      if (cmd.prod) begin
         for (int a = 0; a < AXES; a++)
            for (int i = 0; i < SEG_POINTS; i++)
               prod_ff[a][i] <= PROD_W'($signed({1'b0, w_ff[i]})) * PROD_W'(pt_ff[a][i]);
      end
      if (cmd.sum1) begin
         for (int a = 0; a < AXES; a++) begin
            pair_ff[a][0] <= PAIR_W'(prod_ff[a][0]) + PAIR_W'(prod_ff[a][1]);
            pair_ff[a][1] <= PAIR_W'(prod_ff[a][2]) + PAIR_W'(prod_ff[a][3]);
         end
      end
      if (cmd.sum2) begin
         for (int a = 0; a < AXES; a++)
            acc_ff[a] <= ACC_W'(pair_ff[a][0]) + ACC_W'(pair_ff[a][1]);
      end
      if (cmd.push) begin
         for (int a = 0; a < AXES; a++) crv_ff[a] <= crv_new[a];
         last_ff <= status.is_last;
         if (status.is_last) begin
            // end point opens the next segment
            for (int a = 0; a < AXES; a++) pt_ff[a][0] <= pt_ff[a][SEG_POINTS-1];
         end else begin
            t_ff <= t_ff + step_ff;
         end
      end
   end

   assign rsp_curve_x      = crv_ff[0];
   assign rsp_curve_y      = crv_ff[1];
   assign rsp_curve_z      = crv_ff[2];
   assign rsp_segment_last = last_ff;

endmodule

>>> src/cubic_bezier_tessellator_unit.sv
// cubic bezier tessellator: control points (signed q16.16) come in one word at a
// time; the first four points of a curve close a segment and every further three
// close the next, which starts at the previous end point. each closed segment is
// sampled at t = 0, step, 2*step ... while t <= 1 with bernstein weights, rounded
// half up and saturated, and the last sample of a segment is flagged. step is the
// csr register (unsigned q0.16, reset 4096, values below 1040 act as 1040). each
// closing point starts the per-sample steps: weight squares, weight cubes,
// products, two adder levels, round and push through the output register, where
// the push waits while the receiver stalls. a segment gives n samples, with
// n = floor(65536/step) + 1. the datapath handles one sample at a time; a new
// point is taken once the last sample of a segment sits in the output register.
module cubic_bezier_tessellator_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_write_enable,
   input  logic [cbt_pkg::T_W-1:0]                csr_write_data,
   // control point words
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_start_curve,
   input  logic signed [cbt_pkg::COORD_WIDTH-1:0] req_point_x,
   input  logic signed [cbt_pkg::COORD_WIDTH-1:0] req_point_y,
   input  logic signed [cbt_pkg::COORD_WIDTH-1:0] req_point_z,
   // curve sample words
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [cbt_pkg::COORD_WIDTH-1:0] rsp_curve_x,
   output logic signed [cbt_pkg::COORD_WIDTH-1:0] rsp_curve_y,
   output logic signed [cbt_pkg::COORD_WIDTH-1:0] rsp_curve_z,
   output logic                                  rsp_segment_last
);
   import cbt_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: walks each sample through the datapath stages
   cbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // point store, weight multipliers, blend and output register
   cbt_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_start_curve  (req_start_curve),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .rsp_curve_x      (rsp_curve_x),
      .rsp_curve_y      (rsp_curve_y),
      .rsp_curve_z      (rsp_curve_z),
      .rsp_segment_last (rsp_segment_last)
   );

endmodule

>>> sim/tb_cubic_bezier_tessellator_unit.sv
`timescale 1ns / 100ps

module tb_cubic_bezier_tessellator_unit;
   import cbt_pkg::*;

   localparam int COORD_MAX = 32'h7fffffff;
   localparam int COORD_MIN = 32'h80000000;
   // longest quiet stretch: a segment of 64 samples plus receiver stalls
   localparam int IDLE_LIMIT = 4000;
   // settle time after the last expected sample, so a point that closes no segment is through the block
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_POINTS = 290;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      last;
   } sample_type;

   // one directed control point; first_* is the t = 0 sample, i.e. the segment start point
   typedef struct {
      logic      start;
      coord_type x;
      coord_type y;
      coord_type z;
      logic      has_first;
      coord_type first_x;
      coord_type first_y;
      coord_type first_z;
   } point_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [T_W-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_start_curve = 1'b0;
   coord_type req_point_x = '0;
   coord_type req_point_y = '0;
   coord_type req_point_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   coord_type rsp_curve_x;
   coord_type rsp_curve_y;
   coord_type rsp_curve_z;
   logic rsp_segment_last;

   // predictor state: step register and the points of the open segment
   logic [T_W-1:0] step_reg = STEP_RESET;
   longint seg_x [SEG_POINTS];
   longint seg_y [SEG_POINTS];
   longint seg_z [SEG_POINTS];
   int seg_count = 0;

   sample_type pending_samples [$];
   sample_type fresh [64];
   int fresh_n;

   int err_cnt = 0;
   int idle_cycles = 0;
   int points_sent = 0;
   int samples_seen = 0;
   int segments_seen = 0;
   int burst_left = 0;

   always #5 clock = ~clock;

   cubic_bezier_tessellator_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_start_curve  (req_start_curve),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_curve_x      (rsp_curve_x),
      .rsp_curve_y      (rsp_curve_y),
      .rsp_curve_z      (rsp_curve_z),
      .rsp_segment_last (rsp_segment_last)
   );

   // weighted sum of one axis, rounded half up to q16.16 and saturated
   function automatic coord_type bernstein_blend(input longint p [SEG_POINTS],
                                                  input longint w [SEG_POINTS]);
      longint acc;
      longint r;
      acc = 0;
      for (int i = 0; i < SEG_POINTS; i++) acc += w[i] * p[i];
      r = (acc + (64'sd1 <<< (WGT_FRAC - 1))) >>> WGT_FRAC;
      if (r > longint'(COORD_MAX)) r = COORD_MAX;
      if (r < -longint'(32'h80000000)) r = -longint'(32'h80000000);
      return coord_type'(r);
   endfunction

   function automatic longint round_wgt(input longint w48);
      return (w48 + (64'sd1 <<< (WGT_DROP - 1))) >>> WGT_DROP;
   endfunction

   // take one control point, fill fresh[] with the samples it causes
   task automatic tessellate_point(input logic start, input coord_type x,
                                   input coord_type y, input coord_type z);
      longint step_eff;
      longint t;
      longint u;
      longint w [SEG_POINTS];
      fresh_n = 0;
      if (start) seg_count = 0;
      if (seg_count >= SEG_POINTS) seg_count = 0;
      seg_x[seg_count] = x;
      seg_y[seg_count] = y;
      seg_z[seg_count] = z;
      seg_count++;
      if (seg_count < SEG_POINTS) return;
      step_eff = (step_reg < STEP_MIN) ? STEP_MIN : step_reg;
      t = 0;
      while (t <= 65536 && fresh_n < 64) begin
         u = 65536 - t;
         w[0] = round_wgt(u * u * u);
         w[1] = round_wgt(3 * u * u * t);
         w[2] = round_wgt(3 * u * t * t);
         w[3] = round_wgt(t * t * t);
         fresh[fresh_n].x = bernstein_blend(seg_x, w);
         fresh[fresh_n].y = bernstein_blend(seg_y, w);
         fresh[fresh_n].z = bernstein_blend(seg_z, w);
         fresh[fresh_n].last = (t + step_eff > 65536);
         fresh_n++;
         t += step_eff;
      end
      // end point opens the next segment
      seg_x[0] = seg_x[3];
      seg_y[0] = seg_y[3];
      seg_z[0] = seg_z[3];
      seg_count = 1;
   endtask

   // present one word, hold it until taken, then queue its samples
   task automatic send_point(input logic start, input coord_type x, input coord_type y,
                             input coord_type z);
      int gap;
      if (burst_left == 0) begin
         // end of burst: idle for a while, sometimes not at all
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_start_curve <= start;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      do @(posedge clock); while (!req_ready);
      tessellate_point(start, x, y, z);
      for (int i = 0; i < fresh_n; i++)
         pending_samples.insert(pending_samples.size(), fresh[i]);
      points_sent++;
   endtask

   // block is idle: nothing left to come and the last point has settled
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      wait (pending_samples.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_step(input logic [T_W-1:0] value);
      drain_pipeline();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      step_reg = value;
   endtask

   function automatic coord_type pick_coord();
      case ($urandom_range(0, 19))
         0, 1: return COORD_MAX;
         2, 3: return COORD_MIN;
         4: return '0;
         5: return -1;
         6, 7, 8: return coord_type'($urandom_range(0, 32'h3ffff)) - 32'sh20000;
         9, 10: return COORD_MAX - coord_type'($urandom_range(0, 32'hffff));
         default: return coord_type'($urandom);
      endcase
   endfunction

   // random curves: mostly whole segments, with stray points and cut-off curves mixed in
   task automatic random_curves(input int n_points);
      int sent;
      int len;
      sent = 0;
      while (sent < n_points) begin
         if ($urandom_range(0, 9) == 0) begin
            send_point($urandom_range(0, 1), pick_coord(), pick_coord(), pick_coord());
            sent++;
         end else begin
            len = 4 + 3 * $urandom_range(0, 3);
            // sometimes break the curve off before a segment closes
            if ($urandom_range(0, 7) == 0) len = len - $urandom_range(1, 2);
            for (int i = 0; i < len; i++)
               send_point(i == 0, pick_coord(), pick_coord(), pick_coord());
            sent += len;
         end
      end
   endtask

   // receiver stalls in runs, with quiet stretches where it never stalls
   int stall_left = 0;
   int steady_left = 0;
   always @(posedge clock) begin
      if (steady_left > 0) begin
         steady_left <= steady_left - 1;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         case ($urandom_range(0, 15))
            0: steady_left <= $urandom_range(50, 400);
            1, 2, 3, 4: begin
               rsp_ready <= 1'b0;
               stall_left <= $urandom_range(0, 20);
            end
            default: begin
               rsp_ready <= 1'b1;
               stall_left <= $urandom_range(0, 6);
            end
         endcase
      end
   end

   // compare every sample word against the oldest prediction, plus the watchdog
   sample_type want;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_samples.size() == 0) begin
            $error("curve sample with nothing expected");
            err_cnt++;
         end else begin
            want = pending_samples.pop_front();
            samples_seen++;
            if (rsp_segment_last) segments_seen++;
            if (rsp_curve_x !== want.x) begin
               $error("curve_x: expected %0d got %0d", want.x, rsp_curve_x);
               err_cnt++;
            end
            if (rsp_curve_y !== want.y) begin
               $error("curve_y: expected %0d got %0d", want.y, rsp_curve_y);
               err_cnt++;
            end
            if (rsp_curve_z !== want.z) begin
               $error("curve_z: expected %0d got %0d", want.z, rsp_curve_z);
               err_cnt++;
            end
            if (rsp_segment_last !== want.last) begin
               $error("segment_last: expected %0b got %0b", want.last, rsp_segment_last);
               err_cnt++;
            end
         end
      end
   end

   // directed points at the reset step; typed t = 0 sample is the segment start point
   point_row_type directed [] = '{
      // all-max segment
      '{1, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 0},
      '{0, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 0},
      '{0, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 0},
      '{0, COORD_MAX, COORD_MAX, COORD_MAX, 1, COORD_MAX, COORD_MAX, COORD_MAX},
      // next segment swings from max to min, starts at the shared end point
      '{0, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, 0},
      '{0, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, 0},
      '{0, COORD_MIN, COORD_MIN, COORD_MIN, 1, COORD_MAX, COORD_MAX, COORD_MAX},
      // short curve, broken off by a new start
      '{1, 0, 0, 0, 0, 0, 0, 0},
      '{0, 32'h00010000, -32'sh10000, 32'h00008000, 0, 0, 0, 0},
      // mixed bit patterns and rounding-sized values
      '{1, 1, -1, 32'h00008000, 0, 0, 0, 0},
      '{0, 32'h55555555, 32'haaaaaaaa, 32'h0000ffff, 0, 0, 0, 0},
      '{0, 32'haaaaaaaa, 32'h55555555, -32'sh0000ffff, 0, 0, 0, 0},
      '{0, -32'sh10000, 32'h00030000, 32'h7fff0000, 1, 1, -1, 32'h00008000},
      // start flag on a point that would otherwise close a segment
      '{1, COORD_MIN, COORD_MAX, 0, 0, 0, 0, 0},
      '{0, COORD_MAX, COORD_MIN, -1, 0, 0, 0, 0},
      '{0, COORD_MIN, COORD_MAX, 1, 0, 0, 0, 0},
      '{1, 32'h12345678, -32'sh12345678, 32'h0f0f0f0f, 0, 0, 0, 0},
      '{0, COORD_MIN, COORD_MAX, 0, 0, 0, 0, 0},
      '{0, COORD_MAX, COORD_MIN, 0, 0, 0, 0, 0},
      '{0, 32'h00000000, 32'h00000000, COORD_MIN, 1, 32'h12345678, -32'sh12345678,
         32'h0f0f0f0f},
      // trailing points that never close a segment
      '{0, 32'h00020000, 32'h00020000, 32'h00020000, 0, 0, 0, 0},
      '{0, -32'sh20000, -32'sh20000, -32'sh20000, 0, 0, 0, 0}
   };

   // steps to walk: exact 1.0, above 1.0, the floor, zero, all ones, half, reset value
   logic [T_W-1:0] step_plan [] = '{T_ONE, 17'd70000, STEP_MIN, 17'd0, 17'h1ffff,
                                    17'h08000, STEP_RESET};

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_point(directed[i].start, directed[i].x, directed[i].y, directed[i].z);
         if (directed[i].has_first && (fresh_n == 0 ||
             fresh[0].x !== directed[i].first_x || fresh[0].y !== directed[i].first_y ||
             fresh[0].z !== directed[i].first_z)) begin
            $error("directed point %0d: t = 0 sample not at the segment start", i);
            err_cnt++;
         end
      end

      // each step setting gets its own batch, block drained before every write
      foreach (step_plan[i]) begin
         write_step(step_plan[i]);
         random_curves(RANDOM_POINTS / (step_plan.size() + 1));
      end
      write_step(17'($urandom_range(STEP_MIN, T_ONE)));
      random_curves(RANDOM_POINTS / (step_plan.size() + 1));

      drain_pipeline();
      repeat (20) @(posedge clock);
      $display("covered %0d control points, %0d samples over %0d closed segments",
               points_sent, samples_seen, segments_seen);
      $display("step settings from the 1040 floor and zero up to above 1.0, random stalls");
      if (err_cnt == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
